// ----- sv/sbd_pkg.sv -----
// ---------------------------------------------------------------------------
// sbd_pkg: shared types and constants for the spatial blob deserializer
// Record layout, record bundles, parser phases and status codes.
// ---------------------------------------------------------------------------
package sbd_pkg;

   localparam int unsigned MAX_RECS   = 4;
   localparam int unsigned QUEUE_SIZE = 2;

   localparam logic [31:0] SRID_LOW  = 32'd4210;
   localparam logic [31:0] SRID_HIGH = 32'd4999;
   localparam logic [31:0] SRID_NULL = 32'hFFFF_FFFF;

   localparam int unsigned FLAG_Z = 0;
   localparam int unsigned FLAG_M = 1;
   localparam int unsigned FLAG_P = 3;
   localparam int unsigned FLAG_L = 4;
   localparam int unsigned FLAG_H = 5;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_POINT   = 3'd1,
      KIND_Z       = 3'd2,
      KIND_M       = 3'd3,
      KIND_FIGURE  = 3'd4,
      KIND_SHAPE   = 3'd5,
      KIND_SEGMENT = 3'd6,
      KIND_END     = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NULL_SRID = 3'd1,
      ST_SRID_RANGE = 3'd2,
      ST_BAD_VER   = 3'd3,
      ST_P_AND_L   = 3'd4,
      ST_TRUNCATED = 3'd5,
      ST_RSVD6     = 3'd6,
      ST_RSVD7     = 3'd7
   } status_type;

   typedef enum logic [14:0] {
      PH_SRID  = 15'b000_0000_0000_0001,
      PH_VER   = 15'b000_0000_0000_0010,
      PH_FLAGS = 15'b000_0000_0000_0100,
      PH_NPTS  = 15'b000_0000_0000_1000,
      PH_PTA   = 15'b000_0000_0001_0000,
      PH_PTB   = 15'b000_0000_0010_0000,
      PH_Z     = 15'b000_0000_0100_0000,
      PH_M     = 15'b000_0000_1000_0000,
      PH_NFIG  = 15'b000_0001_0000_0000,
      PH_FIG   = 15'b000_0010_0000_0000,
      PH_NSHP  = 15'b000_0100_0000_0000,
      PH_SHPA  = 15'b000_1000_0000_0000,
      PH_SHPB  = 15'b001_0000_0000_0000,
      PH_NSEG  = 15'b010_0000_0000_0000,
      PH_SEG   = 15'b100_0000_0000_0000
   } phase_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [31:0] item_index;
      logic [63:0] word_a;
      logic [63:0] word_b;
      logic [7:0]  type_code;
      logic [5:0]  property_flags;
      logic [2:0]  status;
   } rec_type;

   // All records caused by one input byte; count is 1..4 when stored
   typedef struct packed {
      logic [2:0]   count;
      rec_type [MAX_RECS-1:0] recs;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic rec_type mk_rec(input kind_type kind, input logic [31:0] idx,
                                      input logic [63:0] a, input logic [63:0] b,
                                      input logic [7:0] tc, input logic [5:0] fl,
                                      input status_type st);
      rec_type r;
      r.record_kind    = kind;
      r.item_index     = idx;
      r.word_a         = a;
      r.word_b         = b;
      r.type_code      = tc;
      r.property_flags = fl;
      r.status         = st;
      return r;
   endfunction

endpackage

// ----- sv/sbd_req_if.sv -----
// ---------------------------------------------------------------------------
// sbd_req_if: blob byte channel
// One blob byte per word, with a marker on the final byte of each blob.
// ---------------------------------------------------------------------------
interface sbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       blob_end;

   modport source (output valid, output data_byte, output blob_end, input ready);
   modport sink   (input valid, input data_byte, input blob_end, output ready);
endinterface

// ----- sv/sbd_rsp_if.sv -----
// ---------------------------------------------------------------------------
// sbd_rsp_if: decoded record channel
// One typed record per word.
// ---------------------------------------------------------------------------
interface sbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  record_kind;
   logic [31:0] item_index;
   logic [63:0] word_a;
   logic [63:0] word_b;
   logic [7:0]  type_code;
   logic [5:0]  property_flags;
   logic [2:0]  status;
   logic        last_of_run;

   modport source (output valid, output record_kind, output item_index, output word_a,
                   output word_b, output type_code, output property_flags, output status,
                   output last_of_run, input ready);
   modport sink   (input valid, input record_kind, input item_index, input word_a,
                   input word_b, input type_code, input property_flags, input status,
                   input last_of_run, output ready);
endinterface

// ----- sv/sbd_front.sv -----
// ---------------------------------------------------------------------------
// sbd_front: blob byte parser
// Assembles fields byte by byte, walks the section phases and builds the
// bundle of records that each byte causes.
// ---------------------------------------------------------------------------
module sbd_front
   import sbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        geo_mode,
   input  qstat_type   qstat,
   sbd_req_if.sink     req_bus,
   output logic        push_valid,
   output bundle_type  push_data
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  bif_ff, bif_in;
   logic [63:0] fshift_ff, fshift_in;
   logic [63:0] held_ff, held_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] ptotal_ff, ptotal_in;
   logic [5:0]  flags_ff, flags_in;
   logic [7:0]  ver_ff, ver_in;
   logic [39:0] part_ff, part_in;
   logic        skip_ff, skip_in;

   logic        accept;
   logic [7:0]  b;
   logic [2:0]  k;
   logic [3:0]  len;
   logic [31:0] w;
   logic [2:0]  n;
   rec_type [MAX_RECS-1:0] recs;
   logic        go_pts, go_z, go_m, go_shp, done;
   logic [31:0] start_cnt;

   assign req_bus.ready = !qstat.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;
   assign k             = bif_ff;

   always_comb begin
      unique case (phase_ff)
         PH_PTA, PH_PTB, PH_Z, PH_M:    len = 4'd8;
         PH_FIG, PH_SHPB:               len = 4'd5;
         PH_VER, PH_FLAGS, PH_SEG:      len = 4'd1;
         default:                       len = 4'd4;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      bif_in    = bif_ff;
      fshift_in = fshift_ff;
      held_in   = held_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      ptotal_in = ptotal_ff;
      flags_in  = flags_ff;
      ver_in    = ver_ff;
      part_in   = part_ff;
      skip_in   = skip_ff;
      n         = 3'd0;
      recs      = '0;
      w         = '0;
      go_pts    = 1'b0;
      go_z      = 1'b0;
      go_m      = 1'b0;
      go_shp    = 1'b0;
      done      = (left_ff == 32'd1);
      start_cnt = '0;

      if (!skip_ff) begin
         if (phase_ff == PH_FIG || phase_ff == PH_SHPB) begin
            if (k == 3'd0) part_in = {32'd0, b};
            else part_in = part_ff | ({32'd0, b} << {k, 3'b000});
         end else if (len > 4'd1) begin
            if (k == 3'd0) fshift_in = {56'd0, b};
            else fshift_in = fshift_ff | ({56'd0, b} << {k, 3'b000});
         end

         if ({1'b0, k} + 4'd1 < len) begin
            bif_in = k + 3'd1;
         end else begin
            bif_in = 3'd0;
            w      = fshift_in[31:0];
            unique case (phase_ff)
               PH_SRID: begin
                  if (geo_mode && w == SRID_NULL) begin
                     recs[n[1:0]] = mk_rec(KIND_END, '0, {32'd0, w}, '0, ver_in, flags_in,
                                           ST_NULL_SRID);
                     n = n + 3'd1;
                     skip_in = 1'b1;
                  end else if (geo_mode && (w < SRID_LOW || w > SRID_HIGH)) begin
                     recs[n[1:0]] = mk_rec(KIND_END, '0, {32'd0, w}, '0, ver_in, flags_in,
                                           ST_SRID_RANGE);
                     n = n + 3'd1;
                     skip_in = 1'b1;
                  end else begin
                     phase_in = PH_VER;
                  end
               end
               PH_VER: begin
                  ver_in = b;
                  if (b > 8'd2) begin
                     recs[n[1:0]] = mk_rec(KIND_END, '0, '0, '0, ver_in, flags_in, ST_BAD_VER);
                     n = n + 3'd1;
                     skip_in = 1'b1;
                  end else begin
                     phase_in = PH_FLAGS;
                  end
               end
               PH_FLAGS: begin
                  flags_in = {(ver_ff == 8'd2) ? b[FLAG_H] : 1'b0, b[4:0]};
                  recs[n[1:0]] = mk_rec(KIND_HEADER, '0, {32'd0, w}, '0, ver_ff, flags_in,
                                        ST_OK);
                  n = n + 3'd1;
                  if (flags_in[FLAG_P] && flags_in[FLAG_L]) begin
                     recs[n[1:0]] = mk_rec(KIND_END, '0, '0, '0, ver_in, flags_in,
                                           ST_P_AND_L);
                     n = n + 3'd1;
                     skip_in = 1'b1;
                  end else if (flags_in[FLAG_P]) begin
                     ptotal_in = 32'd1;
                     phase_in  = PH_PTA;
                     left_in   = 32'd1;
                     count_in  = '0;
                  end else if (flags_in[FLAG_L]) begin
                     ptotal_in = 32'd2;
                     phase_in  = PH_PTA;
                     left_in   = 32'd2;
                     count_in  = '0;
                  end else begin
                     phase_in = PH_NPTS;
                  end
               end
               PH_NPTS: begin
                  ptotal_in = w;
                  if (w == 32'd0) begin
                     go_pts = 1'b1;
                  end else begin
                     phase_in = PH_PTA;
                     left_in  = w;
                     count_in = '0;
                  end
               end
               PH_PTA: begin
                  held_in  = fshift_in;
                  phase_in = PH_PTB;
               end
               PH_PTB: begin
                  // geography streams carry latitude first
                  if (geo_mode) recs[n[1:0]] = mk_rec(KIND_POINT, count_ff, fshift_in,
                                                      held_ff, '0, '0, ST_OK);
                  else recs[n[1:0]] = mk_rec(KIND_POINT, count_ff, held_ff, fshift_in,
                                             '0, '0, ST_OK);
                  n = n + 3'd1;
                  count_in = count_ff + 32'd1;
                  left_in  = left_ff - 32'd1;
                  if (done) go_pts = 1'b1;
                  else phase_in = PH_PTA;
               end
               PH_Z: begin
                  recs[n[1:0]] = mk_rec(KIND_Z, count_ff, fshift_in, '0, '0, '0, ST_OK);
                  n = n + 3'd1;
                  count_in = count_ff + 32'd1;
                  left_in  = left_ff - 32'd1;
                  go_z     = done;
               end
               PH_M: begin
                  recs[n[1:0]] = mk_rec(KIND_M, count_ff, fshift_in, '0, '0, '0, ST_OK);
                  n = n + 3'd1;
                  count_in = count_ff + 32'd1;
                  left_in  = left_ff - 32'd1;
                  go_m     = done;
               end
               PH_NFIG: begin
                  if (w == 32'd0) begin
                     phase_in = PH_NSHP;
                  end else begin
                     phase_in = PH_FIG;
                     left_in  = w;
                     count_in = '0;
                  end
               end
               PH_FIG: begin
                  recs[n[1:0]] = mk_rec(KIND_FIGURE, count_ff, {32'd0, part_in[39:8]}, '0,
                                        part_in[7:0], '0, ST_OK);
                  n = n + 3'd1;
                  count_in = count_ff + 32'd1;
                  left_in  = left_ff - 32'd1;
                  if (done) phase_in = PH_NSHP;
               end
               PH_NSHP: begin
                  if (w == 32'd0) begin
                     go_shp = 1'b1;
                  end else begin
                     phase_in = PH_SHPA;
                     left_in  = w;
                     count_in = '0;
                  end
               end
               PH_SHPA: begin
                  held_in  = {32'd0, w};
                  phase_in = PH_SHPB;
               end
               PH_SHPB: begin
                  recs[n[1:0]] = mk_rec(KIND_SHAPE, count_ff, {32'd0, held_ff[31:0]},
                                        {32'd0, part_in[31:0]}, part_in[39:32], '0, ST_OK);
                  n = n + 3'd1;
                  count_in = count_ff + 32'd1;
                  left_in  = left_ff - 32'd1;
                  if (done) go_shp = 1'b1;
                  else phase_in = PH_SHPA;
               end
               PH_NSEG: begin
                  if (w == 32'd0) begin
                     recs[n[1:0]] = mk_rec(KIND_END, '0, '0, '0, ver_in, flags_in, ST_OK);
                     n = n + 3'd1;
                     skip_in = 1'b1;
                  end else begin
                     phase_in = PH_SEG;
                     left_in  = w;
                     count_in = '0;
                  end
               end
               PH_SEG: begin
                  recs[n[1:0]] = mk_rec(KIND_SEGMENT, count_ff, '0, '0, b, '0, ST_OK);
                  n = n + 3'd1;
                  count_in = count_ff + 32'd1;
                  left_in  = left_ff - 32'd1;
                  if (done) begin
                     recs[n[1:0]] = mk_rec(KIND_END, '0, '0, '0, ver_in, flags_in, ST_OK);
                     n = n + 3'd1;
                     skip_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_SRID;
               end
            endcase

            // section fall-through: empty or synthesized sections chain on
            start_cnt = ptotal_in;
            if (go_pts) begin
               if (flags_in[FLAG_Z] && start_cnt != 32'd0) begin
                  phase_in = PH_Z;
                  left_in  = start_cnt;
                  count_in = '0;
               end else begin
                  go_z = 1'b1;
               end
            end
            if (go_z) begin
               if (flags_in[FLAG_M] && start_cnt != 32'd0) begin
                  phase_in = PH_M;
                  left_in  = start_cnt;
                  count_in = '0;
               end else begin
                  go_m = 1'b1;
               end
            end
            if (go_m) begin
               if (flags_in[FLAG_P] || flags_in[FLAG_L]) begin
                  recs[n[1:0]] = mk_rec(KIND_FIGURE, '0, '0, '0, 8'd1, '0, ST_OK);
                  n = n + 3'd1;
                  recs[n[1:0]] = mk_rec(KIND_SHAPE, '0, {32'd0, SRID_NULL}, '0,
                                        flags_in[FLAG_P] ? 8'd1 : 8'd2, '0, ST_OK);
                  n = n + 3'd1;
                  go_shp = 1'b1;
               end else begin
                  phase_in = PH_NFIG;
               end
            end
            if (go_shp) begin
               if (ver_in == 8'd2) begin
                  phase_in = PH_NSEG;
               end else begin
                  recs[n[1:0]] = mk_rec(KIND_END, '0, '0, '0, ver_in, flags_in, ST_OK);
                  n = n + 3'd1;
                  skip_in = 1'b1;
               end
            end
         end
      end

      if (req_bus.blob_end) begin
         if (!skip_in) begin
            recs[n[1:0]] = mk_rec(KIND_END, '0, '0, '0, ver_in, flags_in, ST_TRUNCATED);
            n = n + 3'd1;
         end
         // restart at the SRID of the next blob
         phase_in  = PH_SRID;
         bif_in    = '0;
         fshift_in = '0;
         held_in   = '0;
         left_in   = '0;
         count_in  = '0;
         ptotal_in = '0;
         flags_in  = '0;
         ver_in    = '0;
         part_in   = '0;
         skip_in   = 1'b0;
      end
   end

   assign push_valid      = accept && (n != 3'd0);
   assign push_data.count = n;
   assign push_data.recs  = recs;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SRID;
         bif_ff    <= '0;
         fshift_ff <= '0;
         held_ff   <= '0;
         left_ff   <= '0;
         count_ff  <= '0;
         ptotal_ff <= '0;
         flags_ff  <= '0;
         ver_ff    <= '0;
         part_ff   <= '0;
         skip_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         bif_ff    <= bif_in;
         fshift_ff <= fshift_in;
         held_ff   <= held_in;
         left_ff   <= left_in;
         count_ff  <= count_in;
         ptotal_ff <= ptotal_in;
         flags_ff  <= flags_in;
         ver_ff    <= ver_in;
         part_ff   <= part_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

// ----- sv/sbd_queue.sv -----
// ---------------------------------------------------------------------------
// sbd_queue: record bundle queue
// Two-entry queue of bundles between the parser and the record sender.
// ---------------------------------------------------------------------------
module sbd_queue
   import sbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  bundle_type  push_data,
   input  logic        pop,
   output bundle_type  head,
   output qstat_type   qstat
);

   localparam int unsigned PW = $clog2(QUEUE_SIZE);

   bundle_type          mem_ff [QUEUE_SIZE];
   logic [PW-1:0]       wr_ff, wr_in;
   logic [PW-1:0]       rd_ff, rd_in;
   logic [PW:0]         level_ff, level_in;
   logic                do_push, do_pop;

   assign qstat.full  = (level_ff == (PW+1)'(QUEUE_SIZE));
   assign qstat.empty = (level_ff == '0);
   assign do_push     = push_valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + PW'(1) : rd_ff;
      level_in = level_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

// ----- sv/sbd_back.sv -----
// ---------------------------------------------------------------------------
// sbd_back: record sender
// Sends the records of the head bundle one per word and releases the bundle
// after its last record.
// ---------------------------------------------------------------------------
module sbd_back
   import sbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  bundle_type  head,
   input  qstat_type   qstat,
   output logic        pop,
   sbd_rsp_if.source   rsp_bus
);

   logic [1:0] sel_ff, sel_in;
   logic       last;
   logic       fire;
   rec_type    rec;

   assign rec  = head.recs[sel_ff];
   assign last = ({1'b0, sel_ff} + 3'd1) == head.count;
   assign fire = rsp_bus.valid && rsp_bus.ready;
   assign pop  = fire && last;

   assign rsp_bus.valid          = !qstat.empty;
   assign rsp_bus.record_kind    = rec.record_kind;
   assign rsp_bus.item_index     = rec.item_index;
   assign rsp_bus.word_a         = rec.word_a;
   assign rsp_bus.word_b         = rec.word_b;
   assign rsp_bus.type_code      = rec.type_code;
   assign rsp_bus.property_flags = rec.property_flags;
   assign rsp_bus.status         = rec.status;
   assign rsp_bus.last_of_run    = last;

   always_comb begin
      sel_in = sel_ff;
      if (fire) begin
         sel_in = last ? 2'd0 : sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

// ----- sv/spatial_blob_deserializer.sv -----
// ---------------------------------------------------------------------------
// spatial_blob_deserializer: streaming spatial blob parser
// Turns a little-endian spatial blob, one byte per word, into typed records.
// ---------------------------------------------------------------------------
// req_bus carries blob bytes (data_byte, blob_end on the final byte); rsp_bus
// carries records (header, point, z, m, figure, shape, segment, end status),
// last_of_run marking the final record caused by one byte. csr_wr_en and
// csr_wr_data write geography_mode; write it only while the block is idle.
// The parser accepts one byte every cycle as long as the two-entry bundle queue
// has room. A byte that causes records writes them as one bundle into the
// queue, and the sender presents the records of the head bundle on rsp_bus,
// delivering one record per cycle while rsp_bus.ready is high; a byte causes
// 0 to 4 records. Sustained rate: one byte per cycle while each byte causes at
// most one record and the receiver is ready. When the receiver stalls, records
// stay on rsp_bus and the queue takes one more bundle behind the waiting one
// before req_bus.ready drops.
// Reset (synchronous) clears the parser to the SRID field of a new blob,
// empties the queue and clears geography_mode.
// ---------------------------------------------------------------------------
module spatial_blob_deserializer
   import sbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   sbd_req_if.sink    req_bus,
   sbd_rsp_if.source  rsp_bus
);

   logic        geo_ff, geo_in;
   logic        push_valid;
   bundle_type  push_data;
   bundle_type  head;
   qstat_type   qstat;
   logic        pop;

   assign geo_in = csr_wr_en ? csr_wr_data : geo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff <= 1'b0;
      end else begin
         geo_ff <= geo_in;
      end
   end

   sbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .geo_mode   (geo_ff),
      .qstat      (qstat),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   sbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   sbd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .qstat   (qstat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   // a nonzero status only ever rides on an end record
   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.record_kind != KIND_END |-> rsp_bus.status == ST_OK)
      else $error("nonzero status on a non-status record");

   // property flags appear only on header and status records
   a_flags_scope: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.record_kind != KIND_END && rsp_bus.record_kind != KIND_HEADER
      |-> rsp_bus.property_flags == 6'd0)
      else $error("property flags on a data record");

   // a stored bundle always holds one to four records
   a_bundle_count: assert property (@(posedge clock) disable iff (reset)
      !qstat.empty |-> head.count != 3'd0 && head.count <= 3'd4)
      else $error("bad bundle record count");

   // the parser never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !qstat.full)
      else $error("bundle pushed into full queue");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: spatial blob deserializer regression
// Streams hand-built and random spatial blobs (clean, cut short, padded with
// trailing bytes, pure noise) through the byte channel in both coordinate
// modes. A local decoder predicts every record and each one is compared field
// by field. Random gaps fall on both channels, and one long output stall backs
// the parser up.
// ---------------------------------------------------------------------------
module testbench
   import sbd_pkg::*;
();

   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned LONG_STALL   = 200;
   localparam int unsigned MAX_MADE     = 3;
   localparam logic [7:0]  VERSION_MAX  = 8'd2;
   localparam logic [7:0]  VERSION_SEGS = 8'd2;
   localparam logic [7:0]  ATTR_STROKE  = 8'd1;
   localparam logic [7:0]  SHAPE_LONE_PT = 8'd1;
   localparam logic [7:0]  SHAPE_LINE   = 8'd2;
   localparam logic [31:0] NO_PARENT    = 32'hFFFF_FFFF;

   typedef enum {BLOB_CLEAN, BLOB_CUT, BLOB_PADDED, BLOB_NOISE} blob_style_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } blob_byte_type;

   typedef struct packed {
      rec_type rec;
      logic    last;
   } due_rec_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   sbd_req_if req_bus ();
   sbd_rsp_if rsp_bus ();

   spatial_blob_deserializer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // stimulus and scoreboard state
   blob_byte_type bytes_pending[$];
   logic [7:0]  blob_bytes[$];
   due_rec_type records_due[$];
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        send_hold  = 1'b0;
   logic        stall_kick = 1'b0;
   int unsigned stall_left = 0;
   int unsigned mismatches = 0;
   int unsigned bytes_taken = 0;
   int unsigned bytes_queued = 0;
   int unsigned blobs_built = 0;
   int unsigned records_checked = 0;

   // decoder state
   logic        geo_mode;
   phase_type   parse_ph;
   logic [2:0]  fld_pos;
   logic [63:0] fld_acc;
   logic [63:0] held_word;
   logic [31:0] items_left;
   logic [31:0] item_idx;
   logic [31:0] npoints;
   logic [5:0]  flags_r;
   logic [7:0]  version_r;
   logic [39:0] tail_acc;
   logic        draining;
   rec_type     step_recs[$];

   function automatic void add_rec(kind_type kind, logic [31:0] idx, logic [63:0] a,
                                   logic [63:0] b, logic [7:0] tc, logic [5:0] fl,
                                   status_type st);
      rec_type r;
      if (step_recs.size() >= MAX_RECS) return;
      r.record_kind    = kind;
      r.item_index     = idx;
      r.word_a         = a;
      r.word_b         = b;
      r.type_code      = tc;
      r.property_flags = fl;
      r.status         = st;
      step_recs.insert(step_recs.size(), r);
   endfunction

   function automatic void close_blob(status_type code, logic [63:0] a);
      add_rec(KIND_END, '0, a, '0, version_r, flags_r, code);
      draining = 1'b1;
   endfunction

   function automatic void open_section(phase_type ph, logic [31:0] count);
      parse_ph   = ph;
      items_left = count;
      item_idx   = '0;
   endfunction

   function automatic bit count_down();
      item_idx++;
      items_left--;
      return items_left == 0;
   endfunction

   function automatic void after_shapes_done();
      if (version_r == VERSION_SEGS) parse_ph = PH_NSEG;
      else close_blob(ST_OK, '0);
   endfunction

   function automatic void after_m_done();
      if (flags_r[FLAG_P] || flags_r[FLAG_L]) begin
         // single point or line: one stroke figure and one root shape
         add_rec(KIND_FIGURE, '0, '0, '0, ATTR_STROKE, '0, ST_OK);
         add_rec(KIND_SHAPE, '0, {32'b0, NO_PARENT}, '0,
                 flags_r[FLAG_P] ? SHAPE_LONE_PT : SHAPE_LINE, '0, ST_OK);
         after_shapes_done();
      end else begin
         parse_ph = PH_NFIG;
      end
   endfunction

   function automatic void after_z_done();
      if (flags_r[FLAG_M] && npoints != 0) open_section(PH_M, npoints);
      else after_m_done();
   endfunction

   function automatic void after_points_done();
      if (flags_r[FLAG_Z] && npoints != 0) open_section(PH_Z, npoints);
      else after_z_done();
   endfunction

   function automatic void load_points(logic [31:0] count);
      npoints = count;
      if (count == 0) after_points_done();
      else open_section(PH_PTA, count);
   endfunction

   function automatic int field_bytes();
      case (parse_ph)
         PH_PTA, PH_PTB, PH_Z, PH_M: return 8;
         PH_FIG, PH_SHPB:            return 5;
         PH_VER, PH_FLAGS, PH_SEG:   return 1;
         default:                    return 4;
      endcase
   endfunction

   function automatic void clear_parser();
      parse_ph   = PH_SRID;
      fld_pos    = '0;
      fld_acc    = '0;
      held_word  = '0;
      items_left = '0;
      item_idx   = '0;
      npoints    = '0;
      flags_r    = '0;
      version_r  = '0;
      tail_acc   = '0;
      draining   = 1'b0;
   endfunction

   function automatic void take_byte(logic [7:0] b);
      int len;
      int k;
      logic [31:0] w;
      len = field_bytes();
      k   = fld_pos;
      if (parse_ph == PH_FIG || parse_ph == PH_SHPB) begin
         if (k == 0) tail_acc = {32'b0, b};
         else tail_acc[8*k +: 8] = b;
      end else if (len > 1) begin
         if (k == 0) fld_acc = {56'b0, b};
         else fld_acc[8*k +: 8] = b;
      end
      if (k + 1 < len) begin
         fld_pos = 3'(k + 1);
         return;
      end
      fld_pos = '0;
      w = fld_acc[31:0];
      case (parse_ph)
         PH_SRID: begin
            if (geo_mode && w == SRID_NULL) close_blob(ST_NULL_SRID, {32'b0, w});
            else if (geo_mode && (w < SRID_LOW || w > SRID_HIGH))
               close_blob(ST_SRID_RANGE, {32'b0, w});
            else parse_ph = PH_VER;
         end
         PH_VER: begin
            version_r = b;
            if (b > VERSION_MAX) close_blob(ST_BAD_VER, '0);
            else parse_ph = PH_FLAGS;
         end
         PH_FLAGS: begin
            // H only exists in version 2
            flags_r = {(version_r == VERSION_SEGS) & b[FLAG_H], b[4:0]};
            add_rec(KIND_HEADER, '0, {32'b0, w}, '0, version_r, flags_r, ST_OK);
            if (flags_r[FLAG_P] && flags_r[FLAG_L]) close_blob(ST_P_AND_L, '0);
            else if (flags_r[FLAG_P]) load_points(32'd1);
            else if (flags_r[FLAG_L]) load_points(32'd2);
            else parse_ph = PH_NPTS;
         end
         PH_NPTS: load_points(w);
         PH_PTA: begin
            held_word = fld_acc;
            parse_ph  = PH_PTB;
         end
         PH_PTB: begin
            if (geo_mode) add_rec(KIND_POINT, item_idx, fld_acc, held_word, '0, '0, ST_OK);
            else add_rec(KIND_POINT, item_idx, held_word, fld_acc, '0, '0, ST_OK);
            if (count_down()) after_points_done();
            else parse_ph = PH_PTA;
         end
         PH_Z: begin
            add_rec(KIND_Z, item_idx, fld_acc, '0, '0, '0, ST_OK);
            if (count_down()) after_z_done();
         end
         PH_M: begin
            add_rec(KIND_M, item_idx, fld_acc, '0, '0, '0, ST_OK);
            if (count_down()) after_m_done();
         end
         PH_NFIG: begin
            if (w == 0) parse_ph = PH_NSHP;
            else open_section(PH_FIG, w);
         end
         PH_FIG: begin
            add_rec(KIND_FIGURE, item_idx, {32'b0, tail_acc[39:8]}, '0, tail_acc[7:0],
                    '0, ST_OK);
            if (count_down()) parse_ph = PH_NSHP;
         end
         PH_NSHP: begin
            if (w == 0) after_shapes_done();
            else open_section(PH_SHPA, w);
         end
         PH_SHPA: begin
            held_word = {32'b0, w};
            parse_ph  = PH_SHPB;
         end
         PH_SHPB: begin
            add_rec(KIND_SHAPE, item_idx, {32'b0, held_word[31:0]}, {32'b0, tail_acc[31:0]},
                    tail_acc[39:32], '0, ST_OK);
            if (count_down()) after_shapes_done();
            else parse_ph = PH_SHPA;
         end
         PH_NSEG: begin
            if (w == 0) close_blob(ST_OK, '0);
            else open_section(PH_SEG, w);
         end
         PH_SEG: begin
            add_rec(KIND_SEGMENT, item_idx, '0, '0, b, '0, ST_OK);
            if (count_down()) close_blob(ST_OK, '0);
         end
         default: parse_ph = PH_SRID;
      endcase
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic fin);
      due_rec_type due;
      step_recs.delete();
      if (!draining) take_byte(b);
      if (fin) begin
         if (!draining) close_blob(ST_TRUNCATED, '0);
         clear_parser();
      end
      foreach (step_recs[i]) begin
         due.rec  = step_recs[i];
         due.last = (i == step_recs.size() - 1);
         records_due.insert(records_due.size(), due);
      end
   endfunction

   // stimulus helpers
   function automatic void put_le(logic [63:0] v, int n);
      for (int i = 0; i < n; i++) blob_bytes.insert(blob_bytes.size(), v[8*i +: 8]);
   endfunction

   function automatic void flush_blob(int unsigned keep);
      blob_byte_type nb;
      for (int unsigned i = 0; i < keep; i++) begin
         nb.data = blob_bytes[i];
         nb.last = (i == keep - 1);
         bytes_pending.insert(bytes_pending.size(), nb);
      end
      blob_bytes.delete();
      bytes_queued += keep;
      blobs_built++;
   endfunction

   function automatic logic [63:0] rand_word();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return '1;
      if (pick == 1) return '0;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] section_count(int unsigned top, bit wide);
      if (wide && $urandom_range(3) == 0)
         return $urandom_range(1) ? 32'hFFFF_FFFF : 32'($urandom);
      return 32'($urandom_range(top));
   endfunction

   function automatic int unsigned capped(logic [31:0] cnt);
      return (cnt > MAX_MADE) ? MAX_MADE : int'(cnt);
   endfunction

   task automatic queue_blob(blob_style_type style);
      logic [31:0] srid;
      logic [31:0] cnt;
      logic [7:0]  ver;
      logic [7:0]  flg;
      int unsigned pick;
      int unsigned made;
      int unsigned keep;
      bit bad;
      bit wide;
      wide = (style == BLOB_CUT);
      if (style == BLOB_NOISE) begin
         repeat ($urandom_range(12, 1)) blob_bytes.insert(blob_bytes.size(), 8'($urandom));
      end else begin
         pick = $urandom_range(99);
         if (pick < 8) srid = SRID_NULL;
         else if (pick < 13) srid = SRID_LOW - 1;
         else if (pick < 18) srid = SRID_HIGH + 1;
         else if (pick < 22) srid = '0;
         else if (pick < 27) srid = $urandom;
         else if (pick < 32) srid = SRID_LOW;
         else if (pick < 37) srid = SRID_HIGH;
         else srid = $urandom_range(SRID_HIGH, SRID_LOW);
         pick = $urandom_range(99);
         if (pick < 8) ver = 8'($urandom_range(255, 3));
         else if (pick < 18) ver = 8'd0;
         else if (pick < 55) ver = 8'd1;
         else ver = 8'd2;
         flg  = 8'($urandom);
         pick = $urandom_range(99);
         flg[FLAG_P] = (pick < 35);
         flg[FLAG_L] = (pick >= 30 && pick < 55);
         put_le(srid, 4);
         put_le(ver, 1);
         put_le(flg, 1);
         bad = (ver > VERSION_MAX) || (flg[FLAG_P] && flg[FLAG_L]) ||
               (geo_mode && (srid < SRID_LOW || srid > SRID_HIGH));
         if (!bad) begin
            if (flg[FLAG_P]) cnt = 32'd1;
            else if (flg[FLAG_L]) cnt = 32'd2;
            else begin
               cnt = section_count(2, wide);
               put_le(cnt, 4);
            end
            made = capped(cnt);
            repeat (2 * made) put_le(rand_word(), 8);
            if (flg[FLAG_Z]) repeat (made) put_le(rand_word(), 8);
            if (flg[FLAG_M]) repeat (made) put_le(rand_word(), 8);
            if (!flg[FLAG_P] && !flg[FLAG_L]) begin
               cnt = section_count(MAX_MADE, wide);
               put_le(cnt, 4);
               repeat (capped(cnt)) put_le(rand_word(), 5);
               cnt = section_count(MAX_MADE, wide);
               put_le(cnt, 4);
               repeat (capped(cnt)) begin
                  put_le(rand_word(), 4);
                  put_le(rand_word(), 5);
               end
            end
            if (ver == VERSION_SEGS) begin
               cnt = section_count(MAX_MADE, wide);
               put_le(cnt, 4);
               repeat (capped(cnt)) put_le(8'($urandom), 1);
            end
         end
      end
      if (style == BLOB_PADDED)
         repeat ($urandom_range(4, 1)) blob_bytes.insert(blob_bytes.size(), 8'($urandom));
      keep = blob_bytes.size();
      // end the blob early, somewhere inside what was built
      if (style == BLOB_CUT && keep > 1) keep = $urandom_range(keep - 1, 1);
      flush_blob(keep);
   endtask

   task automatic wait_drained();
      int unsigned quiet;
      quiet = 0;
      while (quiet < DRAIN_CYCLES) begin
         @(negedge clock);
         if ((bytes_pending.size() != 0 && !send_hold) || req_bus.valid ||
             records_due.size() != 0 || stall_left != 0) quiet = 0;
         else quiet++;
      end
   endtask

   task automatic write_mode(logic mode);
      csr_wr_data <= mode;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      geo_mode = mode;
   endtask

   task automatic run_phase(logic mode, int unsigned send_pct, int unsigned recv_pct,
                            int unsigned budget, bit squeeze);
      int unsigned start;
      int unsigned pick;
      write_mode(mode);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      start = bytes_queued;
      while (bytes_queued - start < budget) begin
         pick = $urandom_range(99);
         queue_blob(pick < 60 ? BLOB_CLEAN : pick < 75 ? BLOB_CUT :
                    pick < 88 ? BLOB_PADDED : BLOB_NOISE);
      end
      if (squeeze) begin
         // block the output while bytes keep coming, then pause input until empty
         stall_kick <= 1'b1;
         @(negedge clock);
         stall_kick <= 1'b0;
         @(negedge clock);
         while (stall_left != 0) @(negedge clock);
         send_hold <= 1'b1;
         wait_drained();
         send_hold <= 1'b0;
      end
      wait_drained();
   endtask

   // byte driver; predicts records for each word taken
   always @(posedge clock) begin : byte_driver
      blob_byte_type nxt;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= '0;
         req_bus.blob_end  <= 1'b0;
         geo_mode = 1'b0;
         clear_parser();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.data_byte, req_bus.blob_end);
            bytes_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (bytes_pending.size() != 0 && !send_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               nxt = bytes_pending.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= nxt.data;
               req_bus.blob_end  <= nxt.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_kick) stall_left <= LONG_STALL;
      else if (stall_left != 0) stall_left <= stall_left - 1;
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // record monitor
   always @(posedge clock) begin : record_monitor
      due_rec_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (records_due.size() == 0) begin
               $error("record kind %0d arrived with nothing expected", rsp_bus.record_kind);
               mismatches++;
            end else begin
               want = records_due.pop_front();
               check_field("record_kind", want.rec.record_kind, rsp_bus.record_kind);
               check_field("item_index", want.rec.item_index, rsp_bus.item_index);
               check_field("word_a", want.rec.word_a, rsp_bus.word_a);
               check_field("word_b", want.rec.word_b, rsp_bus.word_b);
               check_field("type_code", want.rec.type_code, rsp_bus.type_code);
               check_field("property_flags", want.rec.property_flags, rsp_bus.property_flags);
               check_field("status", want.rec.status, rsp_bus.status);
               check_field("last_of_run", want.last, rsp_bus.last_of_run);
               records_checked++;
            end
         end
         rsp_bus.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.blob_end  = 1'b0;
      rsp_bus.ready     = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_mode(1'b0);

      // lone byte: cut short inside the SRID
      put_le('0, 1);
      flush_blob(1);
      // all-ones SRID, version out of range
      put_le(SRID_NULL, 4);
      put_le(8'hFF, 1);
      flush_blob(5);
      // P and L both set
      put_le('0, 4);
      put_le('0, 1);
      put_le(8'hFF, 1);
      flush_blob(6);
      // version 1, every section empty
      put_le(SRID_LOW, 4);
      put_le(8'd1, 1);
      put_le('0, 1);
      put_le('0, 12);
      flush_blob(18);
      wait_drained();

      run_phase(1'b0, 0, 0, 50, 1'b0);
      run_phase(1'b1, 60, 0, 50, 1'b0);
      run_phase(1'b0, 0, 60, 50, 1'b0);
      run_phase(1'b1, 23, 23, 50, 1'b0);
      run_phase(1'b1, 0, 0, 40, 1'b1);
      wait_drained();

      $display("covered %0d blobs, %0d bytes and %0d records in both coordinate orders,",
               blobs_built, bytes_taken, records_checked);
      $display("with random gaps on both channels and one long output stall");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
